### sv/sfp_pkg.sv
// sfp_pkg: shared types, codes and the crc-8/maxim byte update for the frame parser
// no dependencies
`timescale 1ns / 1ps

package sfp_pkg;

    localparam logic [7:0] CRC_POLY      = 8'h8C;
    localparam logic [7:0] SYNC_FIRST    = 8'h55;
    localparam logic [7:0] SYNC_SECOND   = 8'hAA;
    localparam logic [7:0] REBOOT_RESET  = 8'hDA;

    localparam logic [7:0] CMD_TRIG_LOW  = 8'h00;
    localparam logic [7:0] CMD_TRIG_HIGH = 8'h01;
    localparam logic [7:0] CMD_SEL_FIRST = 8'h05;
    localparam logic [7:0] CMD_SEL_NONE  = 8'h09;
    localparam logic [7:0] CMD_SEL_THIRD = 8'h0C;
    localparam logic [7:0] CMD_SEL_SECTH = 8'h0F;
    localparam logic [7:0] CMD_SEL_SECND = 8'h15;

    localparam logic [7:0] CHAN_ONE      = 8'h01;
    localparam logic [7:0] CHAN_THREE    = 8'h03;

    localparam logic [2:0] SEL_RESET     = 3'd1;

    localparam logic REG_REBOOT_ENABLE = 1'b0;
    localparam logic REG_REBOOT_BYTE   = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_CMD   = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRC   = 3'd5
    } phase_t;

    typedef struct packed {
        logic       reboot_enable;
        logic [7:0] reboot_byte;
    } sfp_cfg_t;

    typedef struct packed {
        logic       frame_ok;
        logic       frame_bad;
        logic       reboot_request;
        logic [7:0] frame_command;
        logic [7:0] frame_length;
        logic [7:0] frame_first_data;
        logic       trigger_pin;
        logic [2:0] select_pins;
        logic [1:0] adc_channel;
    } sfp_result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### sv/sfp_in_reg.sv
// sfp_in_reg: input register stage holding one received byte
// depends on nothing but the timescale
`timescale 1ns / 1ps

module sfp_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte,
    output logic       dn_valid,
    input  logic       dn_ready,
    output logic [7:0] dn_byte
);

    logic       vld_reg;
    logic [7:0] byte_reg;

    assign s_ready  = !vld_reg || dn_ready;
    assign dn_valid = vld_reg;
    assign dn_byte  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            byte_reg <= s_byte;
        end
    end

endmodule

### sv/sfp_parser.sv
// sfp_parser: frame state machine, crc check, command decode and result register
// depends on sfp_pkg
`timescale 1ns / 1ps

module sfp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  sfp_pkg::sfp_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    output logic                res_valid,
    input  logic                res_ready,
    output sfp_pkg::sfp_result_t res
);
    import sfp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  first_reg, first_next;
    logic        trig_reg, trig_next;
    logic [2:0]  sel_reg, sel_next;
    logic [1:0]  adc_reg, adc_next;
    logic        rvld_reg;
    sfp_result_t res_reg, res_next;
    logic        advance;
    logic [7:0]  crc_in;
    logic [7:0]  need;

    assign in_ready  = !rvld_reg || res_ready;
    assign advance   = in_valid && in_ready;
    assign res_valid = rvld_reg;
    assign res       = res_reg;

    // crc start value is zero at the command byte
    assign crc_in = (phase_reg == PH_CMD) ? 8'h00 : crc_reg;
    assign need   = (len_reg == 8'h00) ? 8'h01 : len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 8'h00;
            len_reg   <= 8'h00;
            crc_reg   <= 8'h00;
            cmd_reg   <= 8'h00;
            first_reg <= 8'h00;
            trig_reg  <= 1'b0;
            sel_reg   <= SEL_RESET;
            adc_reg   <= 2'd0;
            rvld_reg  <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                len_reg   <= len_next;
                crc_reg   <= crc_next;
                cmd_reg   <= cmd_next;
                first_reg <= first_next;
                trig_reg  <= trig_next;
                sel_reg   <= sel_next;
                adc_reg   <= adc_next;
            end
            if (in_ready) begin
                rvld_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        cmd_next   = cmd_reg;
        first_next = first_reg;
        trig_next  = trig_reg;
        sel_next   = sel_reg;
        adc_next   = adc_reg;
        res_next   = '0;
        res_next.reboot_request = cfg.reboot_enable && (in_byte == cfg.reboot_byte);

        unique case (phase_reg)
            PH_SYNC2: begin
                phase_next = (in_byte == SYNC_SECOND) ? PH_CMD : PH_IDLE;
            end
            PH_CMD: begin
                cmd_next   = in_byte;
                crc_next   = crc8_update(crc_in, in_byte);
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                len_next   = in_byte;
                crc_next   = crc8_update(crc_in, in_byte);
                cnt_next   = 8'h00;
                phase_next = PH_DATA;
            end
            PH_DATA: begin
                if (cnt_reg == 8'h00) begin
                    first_next = in_byte;
                end
                if (cnt_reg < len_reg) begin
                    crc_next = crc8_update(crc_in, in_byte);
                end
                cnt_next = cnt_reg + 8'h01;
                if (cnt_next >= need) begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC: begin
                if (in_byte == crc_reg) begin
                    res_next.frame_ok = 1'b1;
                    if (len_reg == 8'h01) begin
                        unique case (cmd_reg)
                            CMD_TRIG_LOW:  trig_next = 1'b0;
                            CMD_TRIG_HIGH: trig_next = 1'b1;
                            CMD_SEL_FIRST: sel_next  = 3'd1;
                            CMD_SEL_NONE:  sel_next  = 3'd0;
                            CMD_SEL_THIRD: sel_next  = 3'd4;
                            CMD_SEL_SECTH: sel_next  = 3'd6;
                            CMD_SEL_SECND: sel_next  = 3'd2;
                            default: begin
                            end
                        endcase
                        adc_next = (first_reg == CHAN_ONE || first_reg == CHAN_THREE)
                                   ? first_reg[1:0] : 2'd0;
                    end
                end else begin
                    res_next.frame_bad = 1'b1;
                end
                crc_next   = 8'h00;
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = (in_byte == SYNC_FIRST) ? PH_SYNC2 : PH_IDLE;
            end
        endcase

        res_next.frame_command    = cmd_next;
        res_next.frame_length     = len_next;
        res_next.frame_first_data = first_next;
        res_next.trigger_pin      = trig_next;
        res_next.select_pins      = sel_next;
        res_next.adc_channel      = adc_next;
    end

`ifndef SYNTHESIS
    a_ok_bad_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        rvld_reg |-> !(res_reg.frame_ok && res_reg.frame_bad))
        else $error("frame flagged good and bad together");

    a_crc_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && phase_reg == PH_CRC) |=> (phase_reg == PH_IDLE && crc_reg == 8'h00))
        else $error("parser did not return to idle after crc byte");

    a_levels_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && phase_reg == PH_CRC) |=> ($stable(trig_reg) && $stable(sel_reg)
                                                && $stable(adc_reg)))
        else $error("pin levels changed outside a frame end");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (cnt_reg < len_reg || cnt_reg == 8'h00))
        else $error("data count beyond frame length");

    a_flag_needs_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && phase_reg != PH_CRC) |=> (!res_reg.frame_ok && !res_reg.frame_bad))
        else $error("frame flag raised on a non-crc byte");
`endif

endmodule

### sv/serial_frame_parser_crc8_command.sv
// Serial frame parser with CRC-8/MAXIM check: takes one received byte per request and
// returns one result per byte. A byte is held in the input register and is parsed on
// its way into the result register; one byte per cycle is sustained while the result
// side keeps up. Configuration writes are accepted at any time and take effect on the
// next parsed byte.
// depends on sfp_pkg, sfp_in_reg, sfp_parser
`timescale 1ns / 1ps

module serial_frame_parser_crc8_command (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_frame_ok,
    output logic       m_frame_bad,
    output logic       m_reboot_request,
    output logic [7:0] m_frame_command,
    output logic [7:0] m_frame_length,
    output logic [7:0] m_frame_first_data,
    output logic       m_trigger_pin,
    output logic [2:0] m_select_pins,
    output logic [1:0] m_adc_channel
);
    import sfp_pkg::*;

    sfp_cfg_t    cfg_reg;
    sfp_result_t res;
    logic        pv_valid;
    logic        pv_ready;
    logic [7:0]  pv_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reboot_enable <= 1'b1;
            cfg_reg.reboot_byte   <= REBOOT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_REBOOT_ENABLE: cfg_reg.reboot_enable <= cfg_data[0];
                REG_REBOOT_BYTE:   cfg_reg.reboot_byte   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    sfp_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_byte   (s_rx_byte),
        .dn_valid (pv_valid),
        .dn_ready (pv_ready),
        .dn_byte  (pv_byte)
    );

    sfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (pv_valid),
        .in_ready  (pv_ready),
        .in_byte   (pv_byte),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    assign m_frame_ok         = res.frame_ok;
    assign m_frame_bad        = res.frame_bad;
    assign m_reboot_request   = res.reboot_request;
    assign m_frame_command    = res.frame_command;
    assign m_frame_length     = res.frame_length;
    assign m_frame_first_data = res.frame_first_data;
    assign m_trigger_pin      = res.trigger_pin;
    assign m_select_pins      = res.select_pins;
    assign m_adc_channel      = res.adc_channel;

endmodule

### tb/serial_frame_parser_crc8_command_test.sv
// self-checking bench for serial_frame_parser_crc8_command: a bit-accurate frame parser
// predictor checks every result, with random stalls on the byte and result channels
// depends on sfp_pkg and serial_frame_parser_crc8_command
`timescale 1ns / 1ps

module serial_frame_parser_crc8_command_test;

    import sfp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data  = 8'h00;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic       m_frame_ok;
    logic       m_frame_bad;
    logic       m_reboot_request;
    logic [7:0] m_frame_command;
    logic [7:0] m_frame_length;
    logic [7:0] m_frame_first_data;
    logic       m_trigger_pin;
    logic [2:0] m_select_pins;
    logic [1:0] m_adc_channel;

    serial_frame_parser_crc8_command uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_ok        (m_frame_ok),
        .m_frame_bad       (m_frame_bad),
        .m_reboot_request  (m_reboot_request),
        .m_frame_command   (m_frame_command),
        .m_frame_length    (m_frame_length),
        .m_frame_first_data(m_frame_first_data),
        .m_trigger_pin     (m_trigger_pin),
        .m_select_pins     (m_select_pins),
        .m_adc_channel     (m_adc_channel)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // parser mirror
    phase_t     ps_phase;
    logic [7:0] ps_count;
    logic [7:0] ps_length;
    logic [7:0] ps_crc;
    logic [7:0] ps_command;
    logic [7:0] ps_first;
    logic       ps_trigger;
    logic [2:0] ps_select;
    logic [1:0] ps_adc;
    logic       ps_reboot_en;
    logic [7:0] ps_reboot_byte;

    logic [7:0]  rx_stream[$];
    sfp_result_t pending_results[$];

    logic       in_fire     = 1'b0;
    int         send_gap    = 0;
    int         recv_gap    = 0;
    int         idle_odds   = 8;
    int         cfg_writes  = 0;
    int         idle_cycles = 0;
    int         fault_count = 0;
    int         result_num  = 0;
    int         pushed      = 0;
    logic [7:0] cur_reboot_byte = REBOOT_RESET;

    // bitwise crc-8/maxim, one input bit per shift
    function automatic logic [7:0] maxim_crc(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = {1'b0, c[7:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic sfp_result_t parse_rx_byte(input logic [7:0] b);
        sfp_result_t r;
        logic [7:0]  need;
        r = '0;
        r.reboot_request = ps_reboot_en && (b == ps_reboot_byte);
        case (ps_phase)
            PH_SYNC2: begin
                ps_phase = (b == SYNC_SECOND) ? PH_CMD : PH_IDLE;
            end
            PH_CMD: begin
                ps_command = b;
                ps_crc     = maxim_crc(8'h00, b);
                ps_phase   = PH_LEN;
            end
            PH_LEN: begin
                ps_length = b;
                ps_crc    = maxim_crc(ps_crc, b);
                ps_count  = 8'h00;
                ps_phase  = PH_DATA;
            end
            PH_DATA: begin
                if (ps_count == 8'h00) begin
                    ps_first = b;
                end
                if (ps_count < ps_length) begin
                    ps_crc = maxim_crc(ps_crc, b);
                end
                ps_count = ps_count + 8'd1;
                need = (ps_length == 8'h00) ? 8'd1 : ps_length;
                if (ps_count >= need) begin
                    ps_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                if (b == ps_crc) begin
                    r.frame_ok = 1'b1;
                    if (ps_length == 8'd1) begin
                        case (ps_command)
                            CMD_TRIG_LOW:  ps_trigger = 1'b0;
                            CMD_TRIG_HIGH: ps_trigger = 1'b1;
                            CMD_SEL_FIRST: ps_select  = 3'd1;
                            CMD_SEL_NONE:  ps_select  = 3'd0;
                            CMD_SEL_THIRD: ps_select  = 3'd4;
                            CMD_SEL_SECTH: ps_select  = 3'd6;
                            CMD_SEL_SECND: ps_select  = 3'd2;
                            default: ;
                        endcase
                        if (ps_first == CHAN_ONE || ps_first == CHAN_THREE) begin
                            ps_adc = ps_first[1:0];
                        end else begin
                            ps_adc = 2'd0;
                        end
                    end
                end else begin
                    r.frame_bad = 1'b1;
                end
                ps_crc   = 8'h00;
                ps_phase = PH_IDLE;
            end
            default: begin
                ps_phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_IDLE;
            end
        endcase
        r.frame_command    = ps_command;
        r.frame_length     = ps_length;
        r.frame_first_data = ps_first;
        r.trigger_pin      = ps_trigger;
        r.select_pins      = ps_select;
        r.adc_channel      = ps_adc;
        return r;
    endfunction

    function automatic string fmt_result(input sfp_result_t r);
        return $sformatf("ok=%b bad=%b reboot=%b cmd=%02h len=%02h first=%02h trig=%b sel=%03b adc=%0d",
                         r.frame_ok, r.frame_bad, r.reboot_request, r.frame_command,
                         r.frame_length, r.frame_first_data, r.trigger_pin, r.select_pins,
                         r.adc_channel);
    endfunction

    // request driver and result stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_fire) begin
                if (send_gap > 0) begin
                    s_valid <= 1'b0;
                    send_gap = send_gap - 1;
                end else if (rx_stream.size() != 0) begin
                    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                        send_gap = $urandom_range(0, 4);
                        s_valid <= 1'b0;
                    end else begin
                        s_valid   <= 1'b1;
                        s_rx_byte <= rx_stream.pop_front();
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (recv_gap > 0) begin
                m_ready <= 1'b0;
                recv_gap = recv_gap - 1;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                recv_gap = $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // predictor, result checker and watchdog
    always @(posedge aclk) begin
        sfp_result_t got;
        sfp_result_t want;
        logic        out_fire;
        logic        cfg_fire;
        if (!aresetn) begin
            ps_phase       = PH_IDLE;
            ps_count       = 8'h00;
            ps_length      = 8'h00;
            ps_crc         = 8'h00;
            ps_command     = 8'h00;
            ps_first       = 8'h00;
            ps_trigger     = 1'b0;
            ps_select      = SEL_RESET;
            ps_adc         = 2'd0;
            ps_reboot_en   = 1'b1;
            ps_reboot_byte = REBOOT_RESET;
            in_fire        = 1'b0;
            idle_cycles    = 0;
        end else begin
            in_fire  = s_valid && s_ready;
            out_fire = m_valid && m_ready;
            cfg_fire = cfg_valid && cfg_ready;
            if (cfg_fire) begin
                case (cfg_index)
                    REG_REBOOT_ENABLE: ps_reboot_en   = cfg_data[0];
                    REG_REBOOT_BYTE:   ps_reboot_byte = cfg_data;
                    default: ;
                endcase
                cfg_writes = cfg_writes + 1;
            end
            if (in_fire) begin
                pending_results.push_back(parse_rx_byte(s_rx_byte));
            end
            if (out_fire) begin
                got = {m_frame_ok, m_frame_bad, m_reboot_request, m_frame_command,
                       m_frame_length, m_frame_first_data, m_trigger_pin, m_select_pins,
                       m_adc_channel};
                if (pending_results.size() == 0) begin
                    fault_count = fault_count + 1;
                    if (fault_count <= REPORT_MAX) begin
                        $display("result %0d arrived with nothing expected: %s",
                                 result_num, fmt_result(got));
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        fault_count = fault_count + 1;
                        if (fault_count <= REPORT_MAX) begin
                            $display("result %0d mismatch", result_num);
                            $display("  expected %s", fmt_result(want));
                            $display("  actual   %s", fmt_result(got));
                        end
                    end
                end
                result_num = result_num + 1;
            end
            if (in_fire || out_fire || cfg_fire) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("serial_frame_parser_crc8_command verification failed");
                    $finish;
                end
            end
        end
    end

    task automatic queue_rx_byte(input logic [7:0] b);
        rx_stream.push_back(b);
        pushed = pushed + 1;
    endtask

    task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] len,
                               input logic [7:0] first, input bit good);
        logic [7:0] crc;
        logic [7:0] b;
        int         n;
        n   = (len == 8'h00) ? 1 : int'(len);
        crc = maxim_crc(8'h00, cmd);
        crc = maxim_crc(crc, len);
        queue_rx_byte(SYNC_FIRST);
        queue_rx_byte(SYNC_SECOND);
        queue_rx_byte(cmd);
        queue_rx_byte(len);
        for (int i = 0; i < n; i++) begin
            b = (i == 0) ? first : 8'($urandom);
            if (i < int'(len)) begin
                crc = maxim_crc(crc, b);
            end
            queue_rx_byte(b);
        end
        queue_rx_byte(good ? crc : crc ^ 8'($urandom_range(1, 255)));
    endtask

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 8))
            0: return CMD_TRIG_LOW;
            1: return CMD_TRIG_HIGH;
            2: return CMD_SEL_FIRST;
            3: return CMD_SEL_NONE;
            4: return CMD_SEL_THIRD;
            5: return CMD_SEL_SECTH;
            6: return CMD_SEL_SECND;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 199);
        if (r < 90) return 8'd1;
        if (r < 120) return 8'd0;
        if (r < 180) return 8'($urandom_range(2, 8));
        if (r < 199) return 8'($urandom_range(9, 40));
        return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'($urandom_range(200, 254));
    endfunction

    function automatic logic [7:0] pick_first();
        int r;
        r = $urandom_range(0, 5);
        return (r < 4) ? 8'(r) : 8'($urandom);
    endfunction

    task automatic queue_random_traffic();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 7) begin
            queue_frame(pick_command(), pick_length(), pick_first(), kind != 7);
        end else if (kind == 8) begin
            // broken frame start
            queue_rx_byte(SYNC_FIRST);
            if ($urandom_range(0, 1) == 1) begin
                queue_rx_byte(8'($urandom));
            end else begin
                queue_rx_byte(SYNC_SECOND);
                queue_rx_byte(pick_command());
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 3))
                    0: queue_rx_byte(SYNC_FIRST);
                    1: queue_rx_byte(SYNC_SECOND);
                    2: queue_rx_byte(cur_reboot_byte);
                    default: queue_rx_byte(8'($urandom));
                endcase
            end
        end
    endtask

    task automatic wait_idle();
        while (rx_stream.size() != 0 || s_valid || pending_results.size() != 0) begin
            @(negedge aclk);
            #1;
        end
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        int seen;
        seen = cfg_writes;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (cfg_writes == seen);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic       en;
        logic [7:0] rb;
        int         target;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reboot byte, byte extremes, sync without AA, then good, zero-length and bad-crc frames
        queue_rx_byte(REBOOT_RESET);
        queue_rx_byte(8'h00);
        queue_rx_byte(8'hFF);
        queue_rx_byte(SYNC_FIRST);
        queue_rx_byte(SYNC_FIRST);
        queue_rx_byte(SYNC_SECOND);
        queue_frame(CMD_TRIG_HIGH, 8'd1, CHAN_THREE, 1'b1);
        queue_frame(CMD_SEL_SECTH, 8'd0, 8'hFF, 1'b1);
        queue_frame(CMD_SEL_NONE, 8'd1, CHAN_ONE, 1'b0);

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_idle();
                case (p)
                    1: begin en = 1'b0; rb = REBOOT_RESET; end
                    2: begin en = 1'b1; rb = 8'h00; end
                    3: begin en = 1'b1; rb = 8'hFF; end
                    4: begin en = 1'b1; rb = SYNC_FIRST; end
                    default: begin en = 1'b1; rb = 8'($urandom); end
                endcase
                write_reg(REG_REBOOT_ENABLE, {7'd0, en});
                write_reg(REG_REBOOT_BYTE, rb);
                cur_reboot_byte = rb;
            end
            idle_odds = (p == 5) ? 0 : $urandom_range(3, 20);
            target = pushed + 185;
            while (pushed < target) begin
                queue_random_traffic();
            end
        end

        wait_idle();
        repeat (8) @(negedge aclk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("serial_frame_parser_crc8_command verification clean");
        end else begin
            $display("serial_frame_parser_crc8_command verification failed");
        end
        $finish;
    end

endmodule

### serial_frame_parser_crc8_command.f
sv/sfp_pkg.sv
sv/sfp_in_reg.sv
sv/sfp_parser.sv
sv/serial_frame_parser_crc8_command.sv
tb/serial_frame_parser_crc8_command_test.sv
